// ----- sv/cpaf_pkg.sv -----
// ----------------------------------------------------------------------------
// cpaf_pkg
// Shared types, codes, fixed address ranges and the prefix match function of
// the peer access filter.
// ----------------------------------------------------------------------------
package cpaf_pkg;

  localparam int RULE_SLOTS = 32;
  localparam int SLOT_W     = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam int CFG_IDX_W  = 8;

  localparam logic       KIND_WRITE = 1'b0;
  localparam logic       KIND_QUERY = 1'b1;

  localparam logic [2:0] FAM_IPV4     = 3'd0;
  localparam logic [2:0] FAM_IPV6     = 3'd1;
  localparam logic [2:0] FAM_UNIX     = 3'd2;
  localparam logic [2:0] FAM_ABSTRACT = 3'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_UNIX     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_ABSTRACT = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_PUBLIC   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_NETWORK  = 8'd3;

  localparam logic [7:0] MAX_LEN_V4 = 8'd32;
  localparam logic [7:0] MAX_LEN_V6 = 8'd128;

  typedef struct packed {
    logic        kind;
    logic [2:0]  addr_family;
    logic [63:0] address_high;
    logic [63:0] address_low;
    logic [4:0]  rule_index;
    logic        rule_valid;
    logic        rule_is_deny;
    logic        rule_is_inet6;
    logic [7:0]  rule_prefix_len;
  } req_word_t;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
    logic [7:0]  len;
    logic        is6;
    logic        deny;
    logic        valid;
  } rule_t;

  typedef struct packed {
    logic        is6;
    logic [7:0]  len;
    logic [63:0] hi;
    logic [63:0] lo;
  } range_t;

  typedef struct packed {
    logic              capture;
    logic              write_rule;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              load_out;
  } cmd_t;

  typedef struct packed {
    logic req_query;
    logic req_inet;
    logic out_busy;
  } status_t;

  localparam range_t LOCAL_RANGES [4] = '{
    '{1'b0, 8'd8,   64'h0, 64'h7F000000},
    '{1'b1, 8'd128, 64'h0, 64'h1},
    '{1'b0, 8'd32,  64'h0, 64'h0},
    '{1'b1, 8'd128, 64'h0, 64'h0}
  };

  localparam range_t PRIVATE_RANGES [7] = '{
    '{1'b0, 8'd8,  64'h0, 64'h0A000000},
    '{1'b0, 8'd10, 64'h0, 64'h64400000},
    '{1'b0, 8'd16, 64'h0, 64'hA9FE0000},
    '{1'b0, 8'd12, 64'h0, 64'hAC100000},
    '{1'b0, 8'd16, 64'h0, 64'hC0A80000},
    '{1'b1, 8'd7,  64'hFC00000000000000, 64'h0},
    '{1'b1, 8'd10, 64'hFE80000000000000, 64'h0}
  };

  localparam range_t RESERVED_RANGES [6] = '{
    '{1'b0, 8'd24, 64'h0, 64'hC0000000},
    '{1'b0, 8'd4,  64'h0, 64'hE0000000},
    '{1'b0, 8'd4,  64'h0, 64'hF0000000},
    '{1'b0, 8'd32, 64'h0, 64'hFFFFFFFF},
    '{1'b1, 8'd23, 64'h2001000000000000, 64'h0},
    '{1'b1, 8'd8,  64'hFF00000000000000, 64'h0}
  };

  function automatic logic prefix_match(
    input logic [2:0]  fam,
    input logic [63:0] ahi,
    input logic [63:0] alo,
    input logic        is6,
    input logic [63:0] phi,
    input logic [63:0] plo,
    input logic [7:0]  len
  );
    logic [127:0] m6;
    logic [31:0]  m4;
    logic         mapped;
    logic         hit;
    for (int i = 0; i < 128; i++) begin
      m6[127-i] = 8'(i) < len;
    end
    for (int i = 0; i < 32; i++) begin
      m4[31-i] = 8'(i) < len;
    end
    mapped = (fam == FAM_IPV6) && (ahi == 64'h0) && (alo[63:32] == 32'h0000FFFF);
    if (!is6) begin
      hit = ((fam == FAM_IPV4) || mapped) && (((alo[31:0] ^ plo[31:0]) & m4) == 32'h0);
    end else begin
      hit = (fam == FAM_IPV6) && ((({ahi, alo} ^ {phi, plo}) & m6) == 128'h0);
    end
    return hit;
  endfunction

endpackage

// ----- sv/cpaf_channels.sv -----
// ----------------------------------------------------------------------------
// cpaf channels
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface cpaf_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [2:0]  addr_family;
  logic [63:0] address_high;
  logic [63:0] address_low;
  logic [4:0]  rule_index;
  logic        rule_valid;
  logic        rule_is_deny;
  logic        rule_is_inet6;
  logic [7:0]  rule_prefix_len;

  modport source (
    output valid, kind, addr_family, address_high, address_low, rule_index,
           rule_valid, rule_is_deny, rule_is_inet6, rule_prefix_len,
    input  ready
  );
  modport sink (
    input  valid, kind, addr_family, address_high, address_low, rule_index,
           rule_valid, rule_is_deny, rule_is_inet6, rule_prefix_len,
    output ready
  );
endinterface

interface cpaf_rsp_if;
  logic       valid;
  logic       ready;
  logic       allowed;
  logic [7:0] best_allow_prefix;

  modport source (output valid, allowed, best_allow_prefix, input ready);
  modport sink (input valid, allowed, best_allow_prefix, output ready);
endinterface

// ----- sv/cidr_peer_access_filter_unit.sv -----
// ----------------------------------------------------------------------------
// cidr_peer_access_filter_unit
// Peer access filter with a table of allow and deny prefix rules.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one word: kind 0 loads a rule into slot rule_index, kind 1
//   queries a peer address. rsp carries one word per query: allowed and the
//   longest matching allow prefix. Rule loads give no result.
//   cfg_we/cfg_index/cfg_data write the four mode flags; write them only
//   while no query is in flight.
//   A rule load is written as its word is taken. A unix or other-family
//   query goes from capture straight to the finish state. An inet query
//   scans the rule memory one slot a cycle through its single read port,
//   drains, and the next word is taken the cycle after the result is loaded.
//   The result sits in an output register; a new word is taken while it
//   waits. A finished query holds in the sequencer until rsp is free.
//   Reset (rst, synchronous) restores the mode flags, empties the output and
//   returns the table to its power-on contents: slot 0 allows 0.0.0.0/0,
//   slot 1 allows ::/0, the others are empty. No clearing pass is needed.
// ----------------------------------------------------------------------------
module cidr_peer_access_filter_unit import cpaf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_data,
  cpaf_req_if.sink             req,
  cpaf_rsp_if.source           rsp
);

  req_word_t req_word;
  cmd_t      cmd;
  status_t   status;

  always_comb begin
    req_word.kind            = req.kind;
    req_word.addr_family     = req.addr_family;
    req_word.address_high    = req.address_high;
    req_word.address_low     = req.address_low;
    req_word.rule_index      = req.rule_index;
    req_word.rule_valid      = req.rule_valid;
    req_word.rule_is_deny    = req.rule_is_deny;
    req_word.rule_is_inet6   = req.rule_is_inet6;
    req_word.rule_prefix_len = req.rule_prefix_len;
  end

  cpaf_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .status    (status),
    .cmd       (cmd)
  );

  cpaf_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .req_word    (req_word),
    .cmd         (cmd),
    .status      (status),
    .rsp_ready   (rsp.ready),
    .rsp_valid   (rsp.valid),
    .rsp_allowed (rsp.allowed),
    .rsp_best    (rsp.best_allow_prefix)
  );

endmodule

// ----- sv/cpaf_datapath.sv -----
// ----------------------------------------------------------------------------
// cpaf_datapath
// Rule memory, configuration flags, query registers, range checks, scan
// accumulators and the result register.
// ----------------------------------------------------------------------------
module cpaf_datapath import cpaf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_data,
  input  req_word_t            req_word,
  input  cmd_t                 cmd,
  output status_t              status,
  input  logic                 rsp_ready,
  output logic                 rsp_valid,
  output logic                 rsp_allowed,
  output logic [7:0]           rsp_best
);

  logic allow_unix, allow_abstract, allow_public, allow_network;

  rule_t             rule_mem [RULE_SLOTS];
  logic [RULE_SLOTS-1:0] written;
  rule_t             rd_data;
  logic              rd_written;
  logic [SLOT_W-1:0] rd_addr;
  logic              rd_pending;
  rule_t             cur_rule;
  rule_t             wr_rule;
  logic [7:0]        wr_max;
  logic              wr_in_range;

  logic [2:0]  q_fam;
  logic [63:0] q_hi;
  logic [63:0] q_lo;
  logic        q_local, q_private, q_reserved;
  logic        hit_local, hit_private, hit_reserved;

  logic       any_allow;
  logic [7:0] best;
  logic       deny_found;
  logic [7:0] deny_max;
  logic       rule_hit;

  logic       res_allowed;
  logic       inet_allowed;

  always_ff @(posedge clk) begin
    if (rst) begin
      allow_unix     <= 1'b1;
      allow_abstract <= 1'b1;
      allow_public   <= 1'b0;
      allow_network  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ALLOW_UNIX:     allow_unix     <= cfg_data;
        CFG_ALLOW_ABSTRACT: allow_abstract <= cfg_data;
        CFG_ALLOW_PUBLIC:   allow_public   <= cfg_data;
        CFG_ALLOW_NETWORK:  allow_network  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    wr_max           = req_word.rule_is_inet6 ? MAX_LEN_V6 : MAX_LEN_V4;
    wr_rule.hi       = req_word.address_high;
    wr_rule.lo       = req_word.address_low;
    wr_rule.len      = (req_word.rule_prefix_len > wr_max) ? wr_max : req_word.rule_prefix_len;
    wr_rule.is6      = req_word.rule_is_inet6;
    wr_rule.deny     = req_word.rule_is_deny;
    wr_rule.valid    = req_word.rule_valid;
    wr_in_range      = int'(req_word.rule_index) < RULE_SLOTS;
  end

  always_ff @(posedge clk) begin
    if (cmd.write_rule && wr_in_range) begin
      rule_mem[SLOT_W'(req_word.rule_index)] <= wr_rule;
    end
    if (cmd.rd_en) begin
      rd_data <= rule_mem[cmd.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_pending <= 1'b0;
    end else begin
      rd_pending <= cmd.rd_en;
      if (cmd.write_rule && wr_in_range) begin
        written[SLOT_W'(req_word.rule_index)] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_written <= written[cmd.rd_addr];
      rd_addr    <= cmd.rd_addr;
    end
  end

  // unwritten slots read as their reset contents
  always_comb begin
    cur_rule = rd_data;
    if (!rd_written) begin
      cur_rule       = '0;
      cur_rule.valid = (rd_addr == SLOT_W'(0)) || (rd_addr == SLOT_W'(1));
      cur_rule.is6   = (rd_addr == SLOT_W'(1));
    end
  end

  always_comb begin
    hit_local    = 1'b0;
    hit_private  = 1'b0;
    hit_reserved = 1'b0;
    for (int i = 0; i < 4; i++) begin
      hit_local = hit_local | prefix_match(req_word.addr_family, req_word.address_high,
        req_word.address_low, LOCAL_RANGES[i].is6, LOCAL_RANGES[i].hi,
        LOCAL_RANGES[i].lo, LOCAL_RANGES[i].len);
    end
    for (int i = 0; i < 7; i++) begin
      hit_private = hit_private | prefix_match(req_word.addr_family, req_word.address_high,
        req_word.address_low, PRIVATE_RANGES[i].is6, PRIVATE_RANGES[i].hi,
        PRIVATE_RANGES[i].lo, PRIVATE_RANGES[i].len);
    end
    for (int i = 0; i < 6; i++) begin
      hit_reserved = hit_reserved | prefix_match(req_word.addr_family,
        req_word.address_high, req_word.address_low, RESERVED_RANGES[i].is6,
        RESERVED_RANGES[i].hi, RESERVED_RANGES[i].lo, RESERVED_RANGES[i].len);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      q_fam      <= req_word.addr_family;
      q_hi       <= req_word.address_high;
      q_lo       <= req_word.address_low;
      q_local    <= hit_local;
      q_private  <= hit_private;
      q_reserved <= hit_reserved;
    end
  end

  assign rule_hit = cur_rule.valid &&
    prefix_match(q_fam, q_hi, q_lo, cur_rule.is6, cur_rule.hi, cur_rule.lo, cur_rule.len);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      any_allow  <= 1'b0;
      best       <= 8'd0;
      deny_found <= 1'b0;
      deny_max   <= 8'd0;
    end else if (rd_pending && rule_hit) begin
      if (cur_rule.deny) begin
        deny_found <= 1'b1;
        if (!deny_found || (cur_rule.len > deny_max)) begin
          deny_max <= cur_rule.len;
        end
      end else begin
        any_allow <= 1'b1;
        if (cur_rule.len > best) begin
          best <= cur_rule.len;
        end
      end
    end
  end

  always_comb begin
    inet_allowed = (allow_public && !q_private && !q_local && !q_reserved) ||
                   (allow_network && !q_local && !q_reserved) || any_allow;
    case (q_fam)
      FAM_UNIX:     res_allowed = allow_unix;
      FAM_ABSTRACT: res_allowed = allow_abstract;
      FAM_IPV4,
      FAM_IPV6:     res_allowed = inet_allowed && !(deny_found && (deny_max >= best));
      default:      res_allowed = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp_allowed <= res_allowed;
      rsp_best    <= ((q_fam == FAM_IPV4) || (q_fam == FAM_IPV6)) ? best : 8'd0;
    end
  end

  always_comb begin
    status.req_query = (req_word.kind == KIND_QUERY);
    status.req_inet  = (req_word.addr_family == FAM_IPV4) ||
                       (req_word.addr_family == FAM_IPV6);
    status.out_busy  = rsp_valid && !rsp_ready;
  end

  a_best_in_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_best <= MAX_LEN_V6))
    else $error("best prefix beyond 128");

endmodule

// ----- sv/cpaf_controller.sv -----
// ----------------------------------------------------------------------------
// cpaf_controller
// Sequencer: takes a word, loads rules, scans the rule memory for an inet
// query and hands the result to the output register.
// ----------------------------------------------------------------------------
module cpaf_controller import cpaf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t            state, state_next;
  logic [SLOT_W-1:0] cnt, cnt_next;
  logic              accept;

  assign req_ready = (state == S_IDLE) && !rst;
  assign accept    = req_valid && req_ready;

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    cmd.capture    = 1'b0;
    cmd.write_rule = 1'b0;
    cmd.rd_en      = 1'b0;
    cmd.rd_addr    = cnt;
    cmd.load_out   = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (status.req_query) begin
            cmd.capture = 1'b1;
            cnt_next    = '0;
            state_next  = status.req_inet ? S_SCAN : S_FINISH;
          end else begin
            cmd.write_rule = 1'b1;
          end
        end
      end
      S_SCAN: begin
        cmd.rd_en = 1'b1;
        cnt_next  = cnt + SLOT_W'(1);
        if (cnt == SLOT_W'(RULE_SLOTS - 1)) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!status.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !status.out_busy)
    else $error("result loaded while output still held");

  a_scan_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && status.req_query && status.req_inet) |=> (state == S_SCAN && cnt == '0))
    else $error("query scan did not start at slot zero");

  a_drain_to_finish: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRAIN) |=> (state == S_FINISH))
    else $error("drain did not lead to finish");

endmodule

// ----- test/cpaf_verdict_checker.sv -----
// ----------------------------------------------------------------------------
// cpaf_verdict_checker
// Watches the request, result and mode-write ports of the peer access filter.
// Keeps its own copy of the rule table and mode flags, works out the verdict
// of every accepted query word and compares it field by field with the result
// words in order. Reports the first mismatches and counts all of them.
// ----------------------------------------------------------------------------
module cpaf_verdict_checker import cpaf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_data,
  cpaf_req_if                  req,
  cpaf_rsp_if                  rsp,
  output int                   mismatches,
  output int                   verdicts_open,
  output int                   rule_loads,
  output int                   queries,
  output int                   admitted
);

  typedef struct packed {
    logic       allowed;
    logic [7:0] best;
  } verdict_t;

  logic [63:0] tbl_hi    [RULE_SLOTS];
  logic [63:0] tbl_lo    [RULE_SLOTS];
  logic [7:0]  tbl_len   [RULE_SLOTS];
  logic        tbl_valid [RULE_SLOTS];
  logic        tbl_deny  [RULE_SLOTS];
  logic        tbl_is6   [RULE_SLOTS];
  logic        admit_unix, admit_abstract, admit_public, admit_network;
  verdict_t    verdicts_due [$];

  function automatic logic prefix_covers(input logic [2:0]   fam,
                                         input logic [127:0] peer,
                                         input logic         is6,
                                         input logic [127:0] pfx,
                                         input logic [7:0]   len);
    int           bits;
    logic [127:0] keep;
    logic         v4_view;
    v4_view = (fam == FAM_IPV4) ||
              ((fam == FAM_IPV6) && (peer[127:32] == 96'h0000FFFF));
    if (!is6) begin
      bits = (len > 8'd32) ? 32 : int'(len);
      keep = (bits == 0) ? '0 : {96'h0, ~32'h0 << (32 - bits)};
      return v4_view && (((peer ^ pfx) & keep) == '0);
    end
    bits = (len > 8'd128) ? 128 : int'(len);
    keep = (bits == 0) ? '0 : ~128'h0 << (128 - bits);
    return (fam == FAM_IPV6) && (((peer ^ pfx) & keep) == '0);
  endfunction

  function automatic verdict_t decide_peer(input logic [2:0] fam, input logic [127:0] peer);
    verdict_t v;
    logic     loc, prv, rsv;
    v = '0;
    if (fam == FAM_UNIX) begin
      v.allowed = admit_unix;
      return v;
    end
    if (fam == FAM_ABSTRACT) begin
      v.allowed = admit_abstract;
      return v;
    end
    if (fam != FAM_IPV4 && fam != FAM_IPV6) return v;
    loc = prefix_covers(fam, peer, 1'b0, 128'h7F000000, 8'd8) ||
          prefix_covers(fam, peer, 1'b1, 128'h1, 8'd128) ||
          prefix_covers(fam, peer, 1'b0, 128'h0, 8'd32) ||
          prefix_covers(fam, peer, 1'b1, 128'h0, 8'd128);
    prv = prefix_covers(fam, peer, 1'b0, 128'h0A000000, 8'd8) ||
          prefix_covers(fam, peer, 1'b0, 128'h64400000, 8'd10) ||
          prefix_covers(fam, peer, 1'b0, 128'hA9FE0000, 8'd16) ||
          prefix_covers(fam, peer, 1'b0, 128'hAC100000, 8'd12) ||
          prefix_covers(fam, peer, 1'b0, 128'hC0A80000, 8'd16) ||
          prefix_covers(fam, peer, 1'b1, {64'hFC00000000000000, 64'h0}, 8'd7) ||
          prefix_covers(fam, peer, 1'b1, {64'hFE80000000000000, 64'h0}, 8'd10);
    rsv = prefix_covers(fam, peer, 1'b0, 128'hC0000000, 8'd24) ||
          prefix_covers(fam, peer, 1'b0, 128'hE0000000, 8'd4) ||
          prefix_covers(fam, peer, 1'b0, 128'hF0000000, 8'd4) ||
          prefix_covers(fam, peer, 1'b0, 128'hFFFFFFFF, 8'd32) ||
          prefix_covers(fam, peer, 1'b1, {64'h2001000000000000, 64'h0}, 8'd23) ||
          prefix_covers(fam, peer, 1'b1, {64'hFF00000000000000, 64'h0}, 8'd8);
    if (admit_public && !prv && !loc && !rsv) v.allowed = 1'b1;
    if (admit_network && !loc && !rsv) v.allowed = 1'b1;
    for (int i = 0; i < RULE_SLOTS; i++) begin
      if (tbl_valid[i] && !tbl_deny[i] &&
          prefix_covers(fam, peer, tbl_is6[i], {tbl_hi[i], tbl_lo[i]}, tbl_len[i])) begin
        if (tbl_len[i] > v.best) v.best = tbl_len[i];
        v.allowed = 1'b1;
      end
    end
    if (v.allowed) begin
      for (int i = 0; i < RULE_SLOTS; i++) begin
        if (tbl_valid[i] && tbl_deny[i] && tbl_len[i] >= v.best &&
            prefix_covers(fam, peer, tbl_is6[i], {tbl_hi[i], tbl_lo[i]}, tbl_len[i]))
          v.allowed = 1'b0;
      end
    end
    return v;
  endfunction

  always @(posedge clk) begin
    verdict_t   want;
    logic [7:0] cap;
    if (rst) begin
      for (int i = 0; i < RULE_SLOTS; i++) begin
        tbl_hi[i]    = '0;
        tbl_lo[i]    = '0;
        tbl_len[i]   = '0;
        tbl_valid[i] = 1'b0;
        tbl_deny[i]  = 1'b0;
        tbl_is6[i]   = 1'b0;
      end
      tbl_valid[0]   = 1'b1;
      tbl_valid[1]   = 1'b1;
      tbl_is6[1]     = 1'b1;
      admit_unix     = 1'b1;
      admit_abstract = 1'b1;
      admit_public   = 1'b0;
      admit_network  = 1'b0;
      verdicts_due.delete();
      mismatches = 0;
      rule_loads = 0;
      queries    = 0;
      admitted   = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ALLOW_UNIX:     admit_unix = cfg_data;
          CFG_ALLOW_ABSTRACT: admit_abstract = cfg_data;
          CFG_ALLOW_PUBLIC:   admit_public = cfg_data;
          CFG_ALLOW_NETWORK:  admit_network = cfg_data;
          default: ;
        endcase
      end
      if (req.valid && req.ready) begin
        if (req.kind == KIND_QUERY) begin
          want = decide_peer(req.addr_family, {req.address_high, req.address_low});
          verdicts_due.push_back(want);
          queries++;
          if (want.allowed) admitted++;
        end else begin
          cap = req.rule_is_inet6 ? MAX_LEN_V6 : MAX_LEN_V4;
          tbl_hi[req.rule_index]    = req.address_high;
          tbl_lo[req.rule_index]    = req.address_low;
          tbl_valid[req.rule_index] = req.rule_valid;
          tbl_deny[req.rule_index]  = req.rule_is_deny;
          tbl_is6[req.rule_index]   = req.rule_is_inet6;
          tbl_len[req.rule_index]   = (req.rule_prefix_len > cap) ? cap : req.rule_prefix_len;
          rule_loads++;
        end
      end
      if (rsp.valid && rsp.ready) begin
        if (verdicts_due.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result word: allowed %0d best %0d",
                     rsp.allowed, rsp.best_allow_prefix);
          mismatches++;
        end else begin
          want = verdicts_due.pop_front();
          if (rsp.allowed !== want.allowed || rsp.best_allow_prefix !== want.best) begin
            if (mismatches < 10)
              $display("result mismatch: expected allowed %0d best %0d, got allowed %0d best %0d",
                       want.allowed, want.best, rsp.allowed, rsp.best_allow_prefix);
            mismatches++;
          end
        end
      end
    end
    verdicts_open = verdicts_due.size();
  end

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Drives the peer access filter with a short directed sequence of rule loads
// and peer queries, then random words in phases with different mode flags and
// stall patterns on both channels. The verdict checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
  import cpaf_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 8'hA5;
  localparam logic [2:0]           FAM_OTHER    = 3'd4;
  localparam logic [2:0]           FAM_LAST     = 3'd7;
  localparam int                   RANDOM_WORDS = 1500;
  localparam int                   PHASES       = 6;
  localparam int                   DRAIN        = RULE_SLOTS + 8;
  localparam int                   LIMIT        = 600000;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic                 cfg_data;
  int                   send_gap_pct;
  int                   take_gap_pct;
  int                   cycles;
  int                   mismatches, verdicts_open, rule_loads, queries, admitted;
  logic [31:0]          v4_seeds [4];
  logic [127:0]         v6_seeds [4];

  cpaf_req_if req ();
  cpaf_rsp_if rsp ();

  cidr_peer_access_filter_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .rsp       (rsp)
  );

  cpaf_verdict_checker verdict_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .req           (req),
    .rsp           (rsp),
    .mismatches    (mismatches),
    .verdicts_open (verdicts_open),
    .rule_loads    (rule_loads),
    .queries       (queries),
    .admitted      (admitted)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp.ready <= !rst && ($urandom_range(99) >= take_gap_pct);
    end
  end

  function automatic logic [127:0] rand128();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic req_word_t scrap_word();
    logic [191:0] fill;
    fill = {rand128(), $urandom, $urandom};
    return fill[$bits(req_word_t)-1:0];
  endfunction

  function automatic logic [127:0] v4_word(input logic [31:0] a);
    logic [127:0] r;
    r = rand128();
    r[31:0] = a;
    return r;
  endfunction

  function automatic logic [31:0] near4(input logic [31:0] a);
    return a ^ ($urandom >> $urandom_range(32));
  endfunction

  function automatic logic [127:0] near6(input logic [127:0] a);
    return a ^ (rand128() >> $urandom_range(128));
  endfunction

  function automatic logic [31:0] v4_anchor();
    case ($urandom_range(15))
      0:       return 32'h7F000001;
      1:       return 32'h0A000000;
      2:       return 32'h64400000;
      3:       return 32'hA9FE0000;
      4:       return 32'hAC100000;
      5:       return 32'hC0A80000;
      6:       return 32'hC0000000;
      7:       return 32'hE0000000;
      8:       return 32'hF0000000;
      9:       return 32'hFFFFFFFF;
      10:      return 32'h0;
      default: return v4_seeds[$urandom_range(3)];
    endcase
  endfunction

  function automatic logic [127:0] v6_anchor();
    case ($urandom_range(11))
      0:       return 128'h1;
      1:       return 128'h0;
      2:       return {64'hFC00000000000000, 64'h0};
      3:       return {64'hFE80000000000000, 64'h0};
      4:       return {64'h2001000000000000, 64'h0};
      5:       return {64'hFF00000000000000, 64'h0};
      6:       return {64'h0, 32'h0000FFFF, v4_anchor()};
      default: return v6_seeds[$urandom_range(3)];
    endcase
  endfunction

  task automatic drive_word(input req_word_t w);
    req.kind            <= w.kind;
    req.addr_family     <= w.addr_family;
    req.address_high    <= w.address_high;
    req.address_low     <= w.address_low;
    req.rule_index      <= w.rule_index;
    req.rule_valid      <= w.rule_valid;
    req.rule_is_deny    <= w.rule_is_deny;
    req.rule_is_inet6   <= w.rule_is_inet6;
    req.rule_prefix_len <= w.rule_prefix_len;
  endtask

  task automatic push_word(input req_word_t w);
    while ($urandom_range(99) < send_gap_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    drive_word(w);
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  task automatic ask(input logic [2:0] fam, input logic [127:0] peer);
    req_word_t w;
    w = scrap_word();
    w.kind = KIND_QUERY;
    w.addr_family = fam;
    {w.address_high, w.address_low} = peer;
    push_word(w);
  endtask

  task automatic put_rule(input logic [4:0] slot, input logic live, input logic deny,
                          input logic is6, input logic [7:0] len, input logic [127:0] pfx);
    req_word_t w;
    w = scrap_word();
    w.kind = KIND_WRITE;
    w.rule_index = slot;
    w.rule_valid = live;
    w.rule_is_deny = deny;
    w.rule_is_inet6 = is6;
    w.rule_prefix_len = len;
    {w.address_high, w.address_low} = pfx;
    push_word(w);
  endtask

  task automatic drain_filter();
    req.valid <= 1'b0;
    @(posedge clk);
    while (verdicts_open != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // modes: bit 0 unix, bit 1 abstract unix, bit 2 public, bit 3 network
  task automatic load_modes(input logic [3:0] modes);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ALLOW_UNIX;
    cfg_data  <= modes[0];
    @(posedge clk);
    cfg_index <= CFG_ALLOW_ABSTRACT;
    cfg_data  <= modes[1];
    @(posedge clk);
    cfg_index <= CFG_ALLOW_PUBLIC;
    cfg_data  <= modes[2];
    @(posedge clk);
    cfg_index <= CFG_ALLOW_NETWORK;
    cfg_data  <= modes[3];
    @(posedge clk);
    cfg_index <= CFG_UNMAPPED;
    cfg_data  <= ~modes[0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [3:0]   modes;
    logic         is6;
    logic [7:0]   len;
    logic [127:0] pfx;
    int           pick;
    send_gap_pct = 0;
    take_gap_pct = 0;
    for (int i = 0; i < 4; i++) begin
      v4_seeds[i] = $urandom;
      v6_seeds[i] = rand128();
    end
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_ALLOW_UNIX;
    cfg_data  <= 1'b0;
    req.valid <= 1'b0;
    drive_word('0);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    ask(FAM_IPV4, v4_word(32'h08080808));
    ask(FAM_IPV6, {64'h2606470047000000, 64'h1111});
    ask(FAM_UNIX, rand128());
    ask(FAM_ABSTRACT, rand128());
    ask(FAM_OTHER, rand128());
    ask(FAM_LAST, rand128());
    put_rule(5'd2, 1'b1, 1'b1, 1'b0, 8'd8, v4_word(32'h0A000000));
    ask(FAM_IPV4, v4_word(32'h0A010203));
    put_rule(5'd3, 1'b1, 1'b0, 1'b0, 8'd16, v4_word(32'h0A01FFFF));
    ask(FAM_IPV4, v4_word(32'h0A010203));
    ask(FAM_IPV6, {64'h0, 32'h0000FFFF, 32'h0A010203});
    put_rule(5'd4, 1'b1, 1'b0, 1'b1, 8'd200, {64'hFE80000000000000, 64'h1});
    ask(FAM_IPV6, {64'hFE80000000000000, 64'h1});
    put_rule(5'd5, 1'b1, 1'b1, 1'b0, 8'd255, v4_word(32'hFFFFFFFF));
    ask(FAM_IPV4, v4_word(32'hFFFFFFFF));
    put_rule(5'd0, 1'b0, 1'b0, 1'b0, 8'd0, '0);
    put_rule(5'd31, 1'b1, 1'b1, 1'b1, 8'd128, 128'h1);
    ask(FAM_IPV4, v4_word(32'h08080808));
    ask(FAM_IPV6, 128'h1);
    drain_filter();
    load_modes(4'b0100);
    ask(FAM_IPV4, v4_word(32'h08080808));
    ask(FAM_IPV4, v4_word(32'hC0A80101));
    ask(FAM_IPV6, {64'hFD12000000000000, 64'h5});
    drain_filter();
    load_modes(4'b1000);
    ask(FAM_IPV4, v4_word(32'hC0A80101));
    ask(FAM_IPV4, v4_word(32'h7F000001));
    ask(FAM_UNIX, rand128());
    ask(FAM_ABSTRACT, rand128());

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_filter();
      case (ph)
        0:       modes = 4'b0000;
        1:       modes = 4'b1111;
        default: modes = 4'($urandom_range(15));
      endcase
      load_modes(modes);
      send_gap_pct = (ph < 2) ? 26 : (ph < 4) ? 77 : 0;
      take_gap_pct = (ph < 2) ? 77 : (ph < 4) ? 26 : 0;
      repeat (RANDOM_WORDS / PHASES) begin
        pick = $urandom_range(99);
        if (pick < 25) begin
          is6 = 1'($urandom_range(1));
          if ($urandom_range(9) == 0) len = 8'($urandom_range(255));
          else len = 8'(is6 ? $urandom_range(128) : $urandom_range(32));
          pfx = is6 ? near6(v6_anchor()) : v4_word(near4(v4_anchor()));
          put_rule(5'($urandom_range(31)), $urandom_range(9) != 0,
                   $urandom_range(99) < 35, is6, len, pfx);
        end else if (pick < 55) begin
          ask(FAM_IPV4, v4_word(near4(v4_anchor())));
        end else if (pick < 78) begin
          ask(FAM_IPV6, near6(v6_anchor()));
        end else if (pick < 86) begin
          ask(FAM_IPV6, {64'h0, 32'h0000FFFF, near4(v4_anchor())});
        end else if (pick < 91) begin
          ask(FAM_UNIX, rand128());
        end else if (pick < 96) begin
          ask(FAM_ABSTRACT, rand128());
        end else begin
          ask(3'($urandom_range(FAM_LAST, FAM_OTHER)), rand128());
        end
      end
    end
    drain_filter();

    $display("Covered %0d rule loads and %0d queries (%0d admitted) over %0d mode settings,",
             rule_loads, queries, admitted, PHASES + 3);
    $display("with sender and receiver stalls swapped between phases and a stall-free stretch.");
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
